>>> design/ecdsa_signature_der_encoder_assert.svh
// ----------------------------------------------------------------------------
// ECDSA DER encoder assertion macros
// Shared property forms for the encoder's port checker.
// ----------------------------------------------------------------------------
`ifndef ECDSA_SIGNATURE_DER_ENCODER_ASSERT_SVH
`define ECDSA_SIGNATURE_DER_ENCODER_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define EDSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define EDSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/edse_pkg.sv
// ----------------------------------------------------------------------------
// ECDSA DER encoder package
// Shared constants, descriptor and sequencer phase types.
// ----------------------------------------------------------------------------
package edse_pkg;

   localparam int KEPT_W = 7;   // holds an offset up to the largest half (64)
   localparam int LEN_W  = 8;   // short-form DER length byte

   localparam logic [7:0] TAG_SEQUENCE = 8'h30;
   localparam logic [7:0] TAG_INTEGER  = 8'h02;
   localparam logic [7:0] SIGN_MASK    = 8'h80;
   localparam logic [7:0] PAD_BYTE     = 8'h00;

   localparam logic [1:0] COUNT_ONE = 2'd1;
   localparam logic [1:0] COUNT_TWO = 2'd2;

   // One finished signature, waiting for encoding
   typedef struct packed {
      logic              bank;
      logic [KEPT_W-1:0] r_kept;
      logic              r_pad;
      logic              r_zero;
      logic [KEPT_W-1:0] s_kept;
      logic              s_pad;
      logic              s_zero;
      logic [LEN_W-1:0]  r_len;
      logic [LEN_W-1:0]  s_len;
      logic [LEN_W-1:0]  seq_len;
   } desc_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_SEQ_TAG,
      PH_SEQ_LEN,
      PH_R_TAG,
      PH_R_LEN,
      PH_R_PAD,
      PH_R_VAL,
      PH_S_TAG,
      PH_S_LEN,
      PH_S_PAD,
      PH_S_VAL
   } phase_type;

endpackage

>>> design/edse_front.sv
// ----------------------------------------------------------------------------
// ECDSA DER encoder front end
// Loads signature bytes into a bank, scans for leading zeros, posts a descriptor.
// ----------------------------------------------------------------------------
module edse_front #(
   parameter int HALF_BYTES = 32,
   parameter int SIG_BYTES  = 2 * HALF_BYTES,
   parameter int SIG_W      = $clog2(SIG_BYTES),
   parameter int KW         = $clog2(HALF_BYTES + 1),
   parameter int AW         = $clog2(2 * SIG_BYTES)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         in_data,
   output logic               desc_valid,
   input  logic               desc_ready,
   output edse_pkg::desc_type desc,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic [7:0]         wr_data
);

   logic [SIG_W-1:0] load_ff, load_in;
   logic             bank_ff, bank_in;
   logic [KW-1:0]    scan_kept_ff, scan_kept_in;
   logic             scan_found_ff, scan_found_in;
   logic             scan_pad_ff, scan_pad_in;
   logic [KW-1:0]    r_kept_ff, r_kept_in;
   logic             r_found_ff, r_found_in;
   logic             r_pad_ff, r_pad_in;

   logic             accept, in_s, half_end, is_last;
   logic [SIG_W-1:0] off_full;
   logic [KW-1:0]    offset, cur_kept;
   logic             cur_found, cur_pad;

   assign in_ready = desc_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      in_s      = load_ff >= SIG_W'(HALF_BYTES);
      off_full  = in_s ? (load_ff - SIG_W'(HALF_BYTES)) : load_ff;
      offset    = KW'(off_full);
      half_end  = offset == KW'(HALF_BYTES - 1);
      is_last   = load_ff == SIG_W'(SIG_BYTES - 1);
      // restart the scan at the first byte of each half
      cur_found = (offset == '0) ? 1'b0 : scan_found_ff;
      cur_kept  = (offset == '0) ? '0 : scan_kept_ff;
      cur_pad   = (offset == '0) ? 1'b0 : scan_pad_ff;
      scan_found_in = cur_found;
      scan_kept_in  = cur_kept;
      scan_pad_in   = cur_pad;
      if (!cur_found) begin
         if (in_data != 8'h00) begin
            scan_found_in = 1'b1;
            scan_kept_in  = offset;
            scan_pad_in   = (in_data & edse_pkg::SIGN_MASK) != 8'h00;
         end else begin
            scan_kept_in  = offset + KW'(1);
         end
      end
      r_kept_in  = r_kept_ff;
      r_found_in = r_found_ff;
      r_pad_in   = r_pad_ff;
      if (half_end && !in_s) begin
         r_kept_in  = scan_kept_in;
         r_found_in = scan_found_in;
         r_pad_in   = scan_pad_in;
      end
      load_in = is_last ? '0 : load_ff + SIG_W'(1);
      bank_in = is_last ? !bank_ff : bank_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= '0;
         bank_ff <= 1'b0;
      end else if (accept) begin
         load_ff <= load_in;
         bank_ff <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         scan_kept_ff  <= scan_kept_in;
         scan_found_ff <= scan_found_in;
         scan_pad_ff   <= scan_pad_in;
         r_kept_ff     <= r_kept_in;
         r_found_ff    <= r_found_in;
         r_pad_ff      <= r_pad_in;
      end
   end

   // descriptor: R from the stored scan, S from the scan of this final byte
   always_comb begin
      desc.bank    = bank_ff;
      desc.r_kept  = edse_pkg::KEPT_W'(r_kept_ff);
      desc.r_pad   = r_pad_ff;
      desc.r_zero  = !r_found_ff;
      desc.s_kept  = edse_pkg::KEPT_W'(scan_kept_in);
      desc.s_pad   = scan_pad_in;
      desc.s_zero  = !scan_found_in;
      desc.r_len   = r_found_ff ?
                     (edse_pkg::LEN_W'(HALF_BYTES) - edse_pkg::LEN_W'(r_kept_ff)
                      + edse_pkg::LEN_W'(r_pad_ff)) : '0;
      desc.s_len   = scan_found_in ?
                     (edse_pkg::LEN_W'(HALF_BYTES) - edse_pkg::LEN_W'(scan_kept_in)
                      + edse_pkg::LEN_W'(scan_pad_in)) : '0;
      desc.seq_len = edse_pkg::LEN_W'(4) + desc.r_len + desc.s_len;
   end

   assign desc_valid = accept && is_last;
   assign wr_en      = accept;
   assign wr_addr    = AW'(load_ff) + (bank_ff ? AW'(SIG_BYTES) : AW'(0));
   assign wr_data    = in_data;

endmodule

>>> design/edse_queue.sv
// ----------------------------------------------------------------------------
// ECDSA DER encoder descriptor queue
// Two-entry queue between the load side and the encode side.
// ----------------------------------------------------------------------------
module edse_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  edse_pkg::desc_type in_desc,
   output logic               out_valid,
   input  logic               out_ready,
   output edse_pkg::desc_type out_desc
);

   edse_pkg::desc_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_desc  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop)      count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= in_desc;
   end

endmodule

>>> design/edse_back.sv
// ----------------------------------------------------------------------------
// ECDSA DER encoder back end
// Holds the two signature banks and sequences the DER bytes into pairs.
// ----------------------------------------------------------------------------
module edse_back #(
   parameter int HALF_BYTES = 32,
   parameter int SIG_BYTES  = 2 * HALF_BYTES,
   parameter int SIG_W      = $clog2(SIG_BYTES),
   parameter int AW         = $clog2(2 * SIG_BYTES)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [7:0]         wr_data,
   input  logic               desc_valid,
   output logic               desc_pop,
   input  edse_pkg::desc_type desc,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_first,
   output logic [7:0]         rsp_second,
   output logic [1:0]         rsp_count,
   output logic               rsp_last
);

   logic [7:0] mem [2 * SIG_BYTES];
   logic [7:0] rd_ff;
   logic [AW-1:0] rd_addr;

   edse_pkg::phase_type phase_ff, phase_in;
   logic [SIG_W-1:0]    idx_ff, idx_in;

   logic       half_ff;
   logic [7:0] hold_ff;
   logic       rsp_valid_ff;
   logic [7:0] rsp_first_ff, rsp_second_ff;
   logic [1:0] rsp_count_ff;
   logic       rsp_last_ff;

   logic       producing, byte_last, out_free, advance, emit, store;
   logic [7:0] byte_val;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // byte shown by the current phase
   always_comb begin
      producing = 1'b1;
      byte_last = 1'b0;
      byte_val  = edse_pkg::PAD_BYTE;
      unique case (phase_ff)
         edse_pkg::PH_IDLE:    producing = 1'b0;
         edse_pkg::PH_SEQ_TAG: byte_val  = edse_pkg::TAG_SEQUENCE;
         edse_pkg::PH_SEQ_LEN: byte_val  = desc.seq_len;
         edse_pkg::PH_R_TAG:   byte_val  = edse_pkg::TAG_INTEGER;
         edse_pkg::PH_R_LEN:   byte_val  = desc.r_len;
         edse_pkg::PH_R_PAD:   byte_val  = edse_pkg::PAD_BYTE;
         edse_pkg::PH_R_VAL:   byte_val  = rd_ff;
         edse_pkg::PH_S_TAG:   byte_val  = edse_pkg::TAG_INTEGER;
         edse_pkg::PH_S_LEN: begin
            byte_val  = desc.s_len;
            byte_last = desc.s_zero;
         end
         edse_pkg::PH_S_PAD:   byte_val  = edse_pkg::PAD_BYTE;
         edse_pkg::PH_S_VAL: begin
            byte_val  = rd_ff;
            byte_last = idx_ff == SIG_W'(SIG_BYTES - 1);
         end
         default:              producing = 1'b0;
      endcase
      // a first byte of a pair parks without needing the output register
      advance  = producing && (out_free || (!half_ff && !byte_last));
      emit     = advance && (half_ff || byte_last);
      store    = advance && !half_ff && !byte_last;
      desc_pop = advance && byte_last;
   end

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      unique case (phase_ff)
         edse_pkg::PH_IDLE:
            if (desc_valid) phase_in = edse_pkg::PH_SEQ_TAG;
         edse_pkg::PH_SEQ_TAG:
            if (advance) phase_in = edse_pkg::PH_SEQ_LEN;
         edse_pkg::PH_SEQ_LEN:
            if (advance) phase_in = edse_pkg::PH_R_TAG;
         edse_pkg::PH_R_TAG:
            if (advance) phase_in = edse_pkg::PH_R_LEN;
         edse_pkg::PH_R_LEN:
            if (advance) begin
               if (desc.r_zero)     phase_in = edse_pkg::PH_S_TAG;
               else if (desc.r_pad) phase_in = edse_pkg::PH_R_PAD;
               else begin
                  phase_in = edse_pkg::PH_R_VAL;
                  idx_in   = SIG_W'(desc.r_kept);
               end
            end
         edse_pkg::PH_R_PAD:
            if (advance) begin
               phase_in = edse_pkg::PH_R_VAL;
               idx_in   = SIG_W'(desc.r_kept);
            end
         edse_pkg::PH_R_VAL:
            if (advance) begin
               if (idx_ff == SIG_W'(HALF_BYTES - 1)) phase_in = edse_pkg::PH_S_TAG;
               else idx_in = idx_ff + SIG_W'(1);
            end
         edse_pkg::PH_S_TAG:
            if (advance) phase_in = edse_pkg::PH_S_LEN;
         edse_pkg::PH_S_LEN:
            if (advance) begin
               if (desc.s_zero)     phase_in = edse_pkg::PH_IDLE;
               else if (desc.s_pad) phase_in = edse_pkg::PH_S_PAD;
               else begin
                  phase_in = edse_pkg::PH_S_VAL;
                  idx_in   = SIG_W'(HALF_BYTES) + SIG_W'(desc.s_kept);
               end
            end
         edse_pkg::PH_S_PAD:
            if (advance) begin
               phase_in = edse_pkg::PH_S_VAL;
               idx_in   = SIG_W'(HALF_BYTES) + SIG_W'(desc.s_kept);
            end
         edse_pkg::PH_S_VAL:
            if (advance) begin
               if (byte_last) phase_in = edse_pkg::PH_IDLE;
               else idx_in = idx_ff + SIG_W'(1);
            end
         default: phase_in = edse_pkg::PH_IDLE;
      endcase
   end

   // read ahead: fetch the byte for the index of the coming cycle
   assign rd_addr = AW'(idx_in) + (desc.bank ? AW'(SIG_BYTES) : AW'(0));

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= edse_pkg::PH_IDLE;
         half_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (store)     half_ff <= 1'b1;
         else if (emit) half_ff <= 1'b0;
         if (emit)           rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (store) hold_ff <= byte_val;
      if (emit) begin
         rsp_first_ff  <= half_ff ? hold_ff : byte_val;
         rsp_second_ff <= half_ff ? byte_val : 8'h00;
         rsp_count_ff  <= half_ff ? edse_pkg::COUNT_TWO : edse_pkg::COUNT_ONE;
         rsp_last_ff   <= byte_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_first  = rsp_first_ff;
   assign rsp_second = rsp_second_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

>>> design/ecdsa_signature_der_encoder.sv
// ----------------------------------------------------------------------------
// ECDSA signature DER encoder
// Packs a raw R||S signature into its DER SEQUENCE of two INTEGERs.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Per item                        Marker
//   req_*     in         one signature byte, R then S    -
//   rsp_*     out        one or two DER bytes            tlast on final item
//
// Flow: the load side takes one byte per cycle while req_tready is high,
//   2*HALF_BYTES bytes per signature. The encode side produces one DER byte
//   per cycle from a one-port bank read while a held result does not stall
//   it, and each result carries up to two of those bytes. Two banks let the
//   next signature load while the last one encodes.
// Reset: synchronous, clears control only; no clearing pass on the banks.
// Stalls: req_tready drops while both banks hold signatures not yet fully encoded;
//   a held result blocks the encoder only when a full pair or the closing
//   byte is ready.
//
module ecdsa_signature_der_encoder #(
   parameter int HALF_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] sig_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] first_byte, [15:8] second_byte,
                                    // [17:16] byte_count, [23:18] zero
   output logic        rsp_tlast    // last_item
);

   localparam int SIG_BYTES = 2 * HALF_BYTES;
   localparam int SIG_W     = $clog2(SIG_BYTES);
   localparam int KW        = $clog2(HALF_BYTES + 1);
   localparam int AW        = $clog2(2 * SIG_BYTES);

   edse_pkg::desc_type push_desc, head_desc;
   logic push_valid, push_ready, head_valid, head_pop;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [7:0]    first_byte, second_byte;
   logic [1:0]    byte_count;

   // Load side: store bytes, find the first kept byte of each half
   edse_front #(
      .HALF_BYTES (HALF_BYTES),
      .SIG_BYTES  (SIG_BYTES),
      .SIG_W      (SIG_W),
      .KW         (KW),
      .AW         (AW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_data    (req_tdata),
      .desc_valid (push_valid),
      .desc_ready (push_ready),
      .desc       (push_desc),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   // Hold up to two finished signatures, one per bank
   edse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_desc   (push_desc),
      .out_valid (head_valid),
      .out_ready (head_pop),
      .out_desc  (head_desc)
   );

   // Encode side: walk the DER layout and pair bytes into results
   edse_back #(
      .HALF_BYTES (HALF_BYTES),
      .SIG_BYTES  (SIG_BYTES),
      .SIG_W      (SIG_W),
      .AW         (AW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .desc_valid (head_valid),
      .desc_pop   (head_pop),
      .desc       (head_desc),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_first  (first_byte),
      .rsp_second (second_byte),
      .rsp_count  (byte_count),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, byte_count, second_byte, first_byte};

endmodule

>>> design/edse_checker.sv
// ----------------------------------------------------------------------------
// ECDSA DER encoder port checker
// Watches the result channel of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "ecdsa_signature_der_encoder_assert.svh"

module edse_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled item holds
   `EDSE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result item changed while stalled")

   `EDSE_ASSERT_NOW(a_count_range, clock, reset, rsp_tvalid, rsp_tdata[17:16] == 2'd1 || rsp_tdata[17:16] == 2'd2, "byte count out of range")

   // a single-byte item only closes an encoding
   `EDSE_ASSERT_NOW(a_single_last, clock, reset, rsp_tvalid && rsp_tdata[17:16] == 2'd1, rsp_tlast, "single-byte item before the end")

   `EDSE_ASSERT_NOW(a_single_zero, clock, reset, rsp_tvalid && rsp_tdata[17:16] == 2'd1, rsp_tdata[15:8] == 8'h00, "unused second byte not zero")

endmodule

bind ecdsa_signature_der_encoder edse_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// ECDSA signature DER encoder testbench
// Streams raw R||S signatures into the encoder byte by byte and checks every
// DER item that comes back against an in-bench encoding of the same bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int HALF     = 32;
   localparam int SIG_LEN  = 2 * HALF;
   localparam int DRAIN    = 80;

   // Shapes of the first kept byte of a half, and of the bytes after it
   typedef enum int {
      FILL_RANDOM,   // any byte, zero included
      FILL_HIGH,     // first kept byte has its sign bit set
      FILL_LOW,      // first kept byte is nonzero with its sign bit clear
      FILL_ONES      // every kept byte is 0xFF
   } fill_kind_type;

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [1:0] byte_count;
      logic       last_item;
   } der_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;      // [7:0] sig_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;              // [7:0] first_byte, [15:8] second_byte,
                                        // [17:16] byte_count, [23:18] zero
   logic        rsp_tlast;              // last_item

   // Signature bytes waiting to be driven
   logic [7:0]  pending_bytes[$];

   // Predictor state: bytes of the signature being loaded, and the DER
   // items still owed by the block, oldest first
   logic [7:0]    sig_store[SIG_LEN];
   int            byte_fill = 0;
   logic [7:0]    der_bytes[$];
   der_item_type  der_expected[$];

   // Handshake and idling state
   logic        req_taken = 1'b0;
   int          req_gap = 0;
   int          req_calm = 0;
   int          rsp_stall = 0;
   int          rsp_calm = 0;

   int          failures = 0;
   int          signatures_done = 0;
   int          items_checked = 0;

   ecdsa_signature_der_encoder #(
      .HALF_BYTES(HALF)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then a long one
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Append one INTEGER for the half starting at base: tag, length, an
   // optional pad byte, then the value with its leading zero bytes dropped.
   // The scan for the first kept byte stops at the end of the half.
   function automatic void add_integer(input int base);
      int         kept;
      logic [7:0] value[$];
      kept = 0;
      while (kept < HALF && sig_store[base + kept] == 8'h00) kept++;
      if (kept < HALF && (sig_store[base + kept] & edse_pkg::SIGN_MASK) != 8'h00)
         value.push_back(edse_pkg::PAD_BYTE);
      for (int i = kept; i < HALF; i++) value.push_back(sig_store[base + i]);
      der_bytes.push_back(edse_pkg::TAG_INTEGER);
      der_bytes.push_back(8'(value.size()));
      foreach (value[i]) der_bytes.push_back(value[i]);
   endfunction

   // Build the DER encoding of the stored signature and split it into
   // two-byte items; an odd tail goes out alone with a zero second byte
   function automatic void predict_encoding();
      der_item_type item;
      der_bytes.delete();
      der_bytes.push_back(edse_pkg::TAG_SEQUENCE);
      der_bytes.push_back(8'h00);
      add_integer(0);
      add_integer(HALF);
      der_bytes[1] = 8'(der_bytes.size() - 2);
      for (int k = 0; k < der_bytes.size(); k += 2) begin
         item.first_byte = der_bytes[k];
         if (k + 1 < der_bytes.size()) begin
            item.second_byte = der_bytes[k + 1];
            item.byte_count  = edse_pkg::COUNT_TWO;
         end else begin
            item.second_byte = 8'h00;
            item.byte_count  = edse_pkg::COUNT_ONE;
         end
         item.last_item = (k + 2 >= der_bytes.size());
         der_expected.push_back(item);
      end
   endfunction

   // Queue one half: a run of leading zero bytes, then the kept bytes
   task automatic queue_half(input int zeros, input fill_kind_type kind);
      logic [7:0] b;
      for (int i = 0; i < HALF; i++) begin
         if (i < zeros)
            b = 8'h00;
         else if (kind == FILL_ONES)
            b = 8'hFF;
         else if (i == zeros && kind == FILL_HIGH)
            b = 8'h80 | 8'($urandom_range(0, 127));
         else if (i == zeros && kind == FILL_LOW)
            b = 8'($urandom_range(1, 127));
         else
            b = 8'($urandom_range(0, 255));
         pending_bytes.push_back(b);
      end
   endtask

   // Random half: mostly no leading zeros, sometimes a few, a long run,
   // or the whole half zero
   task automatic queue_random_half();
      int            pick;
      int            zeros;
      fill_kind_type kind;
      pick = $urandom_range(0, 9);
      if (pick < 5)       zeros = 0;
      else if (pick < 7)  zeros = $urandom_range(1, 3);
      else if (pick == 7) zeros = $urandom_range(4, HALF - 1);
      else if (pick == 8) zeros = HALF - 1;
      else                zeros = HALF;
      pick = $urandom_range(0, 19);
      if (pick < 8)       kind = FILL_RANDOM;
      else if (pick < 13) kind = FILL_HIGH;
      else if (pick < 19) kind = FILL_LOW;
      else                kind = FILL_ONES;
      queue_half(zeros, kind);
   endtask

   // Driver: present the next pending byte at the falling edge; hold it
   // until the block takes it, then leave a random gap
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0 || pending_bytes.size() == 0) begin
            req_tvalid <= 1'b0;
            if (req_gap > 0) req_gap--;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_bytes.pop_front();
            if (req_calm > 0) begin
               req_calm--;
               req_gap = 0;
            end else begin
               req_gap = idle_length();
               if ($urandom_range(0, 99) == 0) req_calm = $urandom_range(30, 120);
            end
         end
      end
   end

   // Receiver back-pressure: random stalls with stretches of none
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_calm > 0)
            rsp_calm--;
         else if ($urandom_range(0, 3) == 0)
            rsp_stall = idle_length();
         else if ($urandom_range(0, 99) == 0)
            rsp_calm = $urandom_range(30, 120);
      end
   end

   // Monitor: check each result item against the oldest expectation, then
   // absorb any accepted signature byte into the predictor
   always @(posedge clock) begin : monitor
      der_item_type got;
      der_item_type want;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.first_byte  = rsp_tdata[7:0];
         got.second_byte = rsp_tdata[15:8];
         got.byte_count  = rsp_tdata[17:16];
         got.last_item   = rsp_tlast;
         if (der_expected.size() == 0) begin
            $error("unexpected DER item %06h (tlast %0b)", rsp_tdata, rsp_tlast);
            failures++;
         end else begin
            want = der_expected.pop_front();
            items_checked++;
            if (got.first_byte !== want.first_byte) begin
               $error("first_byte mismatch: expected %02h, got %02h",
                      want.first_byte, got.first_byte);
               failures++;
            end
            if (got.second_byte !== want.second_byte) begin
               $error("second_byte mismatch: expected %02h, got %02h",
                      want.second_byte, got.second_byte);
               failures++;
            end
            if (got.byte_count !== want.byte_count) begin
               $error("byte_count mismatch: expected %0d, got %0d",
                      want.byte_count, got.byte_count);
               failures++;
            end
            if (got.last_item !== want.last_item) begin
               $error("last_item mismatch: expected %0b, got %0b",
                      want.last_item, got.last_item);
               failures++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         sig_store[byte_fill] = req_tdata;
         byte_fill++;
         if (byte_fill == SIG_LEN) begin
            predict_encoding();
            byte_fill = 0;
            signatures_done++;
         end
      end
   end

   initial begin
      // Directed signatures first
      // all-zero R against a full-length padded S (odd total)
      queue_half(HALF, FILL_RANDOM);
      queue_half(0, FILL_ONES);
      // single-byte R, padded S
      queue_half(HALF - 1, FILL_LOW);
      queue_half(0, FILL_HIGH);
      // both halves zero: shortest encoding
      queue_half(HALF, FILL_RANDOM);
      queue_half(HALF, FILL_RANDOM);
      // both halves all ones: longest encoding
      queue_half(0, FILL_ONES);
      queue_half(0, FILL_ONES);

      // Random signatures, two of them
      repeat (2) begin
         queue_random_half();
         queue_random_half();
      end

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Wait for every byte to be taken, then for every item to drain
      do @(posedge clock); while (pending_bytes.size() != 0 || req_tvalid);
      while (der_expected.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (der_expected.size() != 0) begin
         $error("%0d DER items never arrived", der_expected.size());
         failures++;
      end

      $display("Encoded %0d signatures, %0d DER items compared", signatures_done,
               items_checked);
      $display("Covered zero, one-byte, padded and full-length halves under stalls");
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/edse_pkg.sv
design/edse_front.sv
design/edse_queue.sv
design/edse_back.sv
design/ecdsa_signature_der_encoder.sv
design/edse_checker.sv
dv/testbench.sv
